### design/sem_pkg.sv
`timescale 1ns / 1ps

package sem_pkg;

  localparam int MAX_ROW_PIXELS = 1024;
  localparam int MAX_ROWS       = 1024;
  localparam int MIN_DIM        = 3;

  localparam int PIX_W    = 8;
  localparam int CHANNELS = 3;
  localparam int RGB_W    = PIX_W * CHANNELS;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W    = $clog2(MAX_ROW_PIXELS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int GRAD_W   = 11;
  localparam int PROD_W   = 2 * GRAD_W;
  localparam int SQ_W     = 21;
  localparam int ROOT_W   = 16;
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int STEP_W   = $clog2(ROOT_STEPS);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
  localparam logic [PIX_W-1:0] EDGE_MAX     = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAD,
    S_SQUARE,
    S_ROOT,
    S_DONE
  } sem_state_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  // window indexed [row][col], row 0 on top, col 0 oldest
  typedef pix_t win_t [3][3];

  function automatic grad_t widen(input pix_t p);
    return grad_t'({{(GRAD_W-PIX_W){1'b0}}, p});
  endfunction

  function automatic grad_t grad_x(input win_t w);
    return (widen(w[0][2]) - widen(w[0][0]))
         + ((widen(w[1][2]) - widen(w[1][0])) <<< 1)
         + (widen(w[2][2]) - widen(w[2][0]));
  endfunction

  function automatic grad_t grad_y(input win_t w);
    return (widen(w[2][0]) - widen(w[0][0]))
         + ((widen(w[2][1]) - widen(w[0][1])) <<< 1)
         + (widen(w[2][2]) - widen(w[0][2]));
  endfunction

  // clamp a size register to MIN_DIM..max and return the last index
  function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] max_v);
    logic [CFG_W-1:0] r;
    if (v < CFG_W'(MIN_DIM)) begin
      r = CFG_W'(MIN_DIM - 1);
    end else if (v > max_v) begin
      r = max_v - CFG_W'(1);
    end else begin
      r = v - CFG_W'(1);
    end
    return r;
  endfunction

endpackage

### design/sem_ram.sv
`timescale 1ns / 1ps

module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps

// Sobel 3x3 edge magnitude on an RGB raster stream.
// Pixels enter on pixel_valid/pixel_ready in raster order; each channel of
// every interior pixel gives floor(sqrt(gx^2 + gy^2)) saturated to 255 on
// edge_valid/edge_ready, with frame_last on the final interior word of a frame.
// Border pixels give no word. frame_width/frame_height are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data (always ready); the user must write
// them only while idle, the block does not enforce it. Both previous rows
// live in one 1024 x 48 line memory (upper and middle row side by side), read
// at the pixel's column and written back in the cycle after.
// One pixel is in flight at a time:
//   border pixel   : accept, memory read and write-back
//   interior pixel : accept, gradient, squares, 8 root steps, load
// The bit-serial root unit gives one result bit per channel per cycle from
// one bit pair of the radicand.
// The output register frees the core: a stalled receiver only holds the next
// interior result in its final step until the held word is taken.
// Reset (rst, synchronous) restores 640x480, clears counters and window; the
// line memory content is undefined until the first row has been written.

module sobel_edge_magnitude_rgb (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [sem_pkg::PIX_W-1:0]        pixel_red,
  input  logic [sem_pkg::PIX_W-1:0]        pixel_green,
  input  logic [sem_pkg::PIX_W-1:0]        pixel_blue,
  output logic                             edge_valid,
  input  logic                             edge_ready,
  output logic [sem_pkg::PIX_W-1:0]        edge_red,
  output logic [sem_pkg::PIX_W-1:0]        edge_green,
  output logic [sem_pkg::PIX_W-1:0]        edge_blue,
  output logic                             frame_last
);

  sem_pkg::sem_state_t state, state_next;

  logic [sem_pkg::CFG_W-1:0] frame_width, frame_height;
  logic [sem_pkg::COL_W-1:0] column_count, col_last, col_eff, col_reg;
  logic [sem_pkg::ROW_W-1:0] row_count, row_last, row_eff;
  logic                      emit_reg, last_reg;
  logic [sem_pkg::RGB_W-1:0] px_reg;
  logic [sem_pkg::RGB_W-1:0] win_col0 [3];
  logic [sem_pkg::RGB_W-1:0] win_col1 [3];
  logic [sem_pkg::STEP_W-1:0] step;

  sem_pkg::grad_t             gx_reg [sem_pkg::CHANNELS];
  sem_pkg::grad_t             gy_reg [sem_pkg::CHANNELS];
  logic [sem_pkg::ROOT_W-1:0] rt_val  [sem_pkg::CHANNELS];
  logic [sem_pkg::ROOT_W-1:0] rt_root [sem_pkg::CHANNELS];
  logic                       rt_sat  [sem_pkg::CHANNELS];

  logic                          pixel_acc;
  logic                          ram_rd_en, ram_wr_en, out_load;
  logic [2*sem_pkg::RGB_W-1:0]   ram_rd_data, ram_wr_data;

  sem_pkg::grad_t             gx_c [sem_pkg::CHANNELS];
  sem_pkg::grad_t             gy_c [sem_pkg::CHANNELS];
  logic [sem_pkg::SQ_W-1:0]   sq_c [sem_pkg::CHANNELS];
  logic [sem_pkg::ROOT_W-1:0] val_c  [sem_pkg::CHANNELS];
  logic [sem_pkg::ROOT_W-1:0] root_c [sem_pkg::CHANNELS];
  logic [sem_pkg::ROOT_W:0]   trial  [sem_pkg::CHANNELS];
  logic [sem_pkg::ROOT_W-1:0] bit_c;
  logic [sem_pkg::RGB_W-1:0]  cur_top, cur_mid;

  assign cfg_ready = 1'b1;
  assign pixel_acc = pixel_valid && pixel_ready;

  assign col_last = sem_pkg::COL_W'(sem_pkg::last_index(frame_width,
                      sem_pkg::CFG_W'(sem_pkg::MAX_ROW_PIXELS)));
  assign row_last = sem_pkg::ROW_W'(sem_pkg::last_index(frame_height,
                      sem_pkg::CFG_W'(sem_pkg::MAX_ROWS)));
  // a counter past a shrunk bound takes the last position
  assign col_eff = (column_count > col_last) ? col_last : column_count;
  assign row_eff = (row_count > row_last) ? row_last : row_count;

  assign cur_top     = ram_rd_data[sem_pkg::RGB_W-1:0];
  assign cur_mid     = ram_rd_data[2*sem_pkg::RGB_W-1:sem_pkg::RGB_W];
  // upper row takes the old middle row, middle row takes the new pixel
  assign ram_wr_data = {px_reg, cur_mid};

  sem_ram #(
    .WIDTH(2 * sem_pkg::RGB_W),
    .DEPTH(sem_pkg::MAX_ROW_PIXELS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (col_reg),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (col_eff),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    sem_pkg::win_t w;
    for (int c = 0; c < sem_pkg::CHANNELS; c++) begin
      for (int r = 0; r < 3; r++) begin
        w[r][0] = win_col0[r][c*sem_pkg::PIX_W +: sem_pkg::PIX_W];
        w[r][1] = win_col1[r][c*sem_pkg::PIX_W +: sem_pkg::PIX_W];
      end
      w[0][2] = cur_top[c*sem_pkg::PIX_W +: sem_pkg::PIX_W];
      w[1][2] = cur_mid[c*sem_pkg::PIX_W +: sem_pkg::PIX_W];
      w[2][2] = px_reg[c*sem_pkg::PIX_W +: sem_pkg::PIX_W];
      gx_c[c] = sem_pkg::grad_x(w);
      gy_c[c] = sem_pkg::grad_y(w);
    end
  end

  always_comb begin
    logic signed [sem_pkg::PROD_W-1:0] px2, py2;
    logic [sem_pkg::PROD_W-1:0]        s;
    for (int c = 0; c < sem_pkg::CHANNELS; c++) begin
      px2 = gx_reg[c] * gx_reg[c];
      py2 = gy_reg[c] * gy_reg[c];
      s = sem_pkg::PROD_W'(px2) + sem_pkg::PROD_W'(py2);
      sq_c[c] = s[sem_pkg::SQ_W-1:0];
    end
  end

  // one root step per cycle: test bit pair at 2*(7-step)
  assign bit_c = sem_pkg::ROOT_W'(1 << (sem_pkg::ROOT_W - 2)) >> {step, 1'b0};

  always_comb begin
    for (int c = 0; c < sem_pkg::CHANNELS; c++) begin
      trial[c] = {1'b0, rt_root[c]} + {1'b0, bit_c};
      if ({1'b0, rt_val[c]} >= trial[c]) begin
        val_c[c]  = rt_val[c] - trial[c][sem_pkg::ROOT_W-1:0];
        root_c[c] = (rt_root[c] >> 1) + bit_c;
      end else begin
        val_c[c]  = rt_val[c];
        root_c[c] = rt_root[c] >> 1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sem_pkg::S_IDLE: begin
        if (pixel_acc) begin
          state_next = sem_pkg::S_GRAD;
        end
      end
      sem_pkg::S_GRAD: begin
        state_next = emit_reg ? sem_pkg::S_SQUARE : sem_pkg::S_IDLE;
      end
      sem_pkg::S_SQUARE: begin
        state_next = sem_pkg::S_ROOT;
      end
      sem_pkg::S_ROOT: begin
        if (step == sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1)) begin
          state_next = sem_pkg::S_DONE;
        end
      end
      sem_pkg::S_DONE: begin
        if (!edge_valid || edge_ready) begin
          state_next = sem_pkg::S_IDLE;
        end
      end
      default: state_next = sem_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pixel_ready = 1'b0;
    ram_wr_en   = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      sem_pkg::S_IDLE:   pixel_ready = 1'b1;
      sem_pkg::S_GRAD:   ram_wr_en = 1'b1;
      sem_pkg::S_SQUARE: ;
      sem_pkg::S_ROOT:   ;
      sem_pkg::S_DONE:   out_load = !edge_valid || edge_ready;
      default: ;
    endcase
    ram_rd_en = pixel_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sem_pkg::S_IDLE;
      frame_width  <= sem_pkg::WIDTH_RESET;
      frame_height <= sem_pkg::HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
      step         <= '0;
      edge_valid   <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win_col0[r] <= '0;
        win_col1[r] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sem_pkg::CFG_FRAME_WIDTH) begin
          frame_width <= cfg_data;
        end else if (cfg_index == sem_pkg::CFG_FRAME_HEIGHT) begin
          frame_height <= cfg_data;
        end
      end
      if (pixel_acc) begin
        if (col_eff == col_last) begin
          column_count <= '0;
          row_count    <= (row_eff == row_last) ? '0 : row_eff + 1'b1;
        end else begin
          column_count <= col_eff + 1'b1;
          row_count    <= row_eff;
        end
      end
      if (state == sem_pkg::S_GRAD) begin
        for (int r = 0; r < 3; r++) begin
          win_col0[r] <= win_col1[r];
        end
        win_col1[0] <= cur_top;
        win_col1[1] <= cur_mid;
        win_col1[2] <= px_reg;
      end
      if (state == sem_pkg::S_SQUARE) begin
        step <= '0;
      end else if (state == sem_pkg::S_ROOT) begin
        step <= step + 1'b1;
      end
      if (out_load) begin
        edge_valid <= 1'b1;
      end else if (edge_ready) begin
        edge_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      px_reg   <= {pixel_blue, pixel_green, pixel_red};
      col_reg  <= col_eff;
      emit_reg <= (row_eff >= sem_pkg::ROW_W'(2)) && (col_eff >= sem_pkg::COL_W'(2));
      last_reg <= (row_eff == row_last) && (col_eff == col_last);
    end
    for (int c = 0; c < sem_pkg::CHANNELS; c++) begin
      if (state == sem_pkg::S_GRAD) begin
        gx_reg[c] <= gx_c[c];
        gy_reg[c] <= gy_c[c];
      end
      if (state == sem_pkg::S_SQUARE) begin
        rt_val[c]  <= sq_c[c][sem_pkg::ROOT_W-1:0];
        rt_root[c] <= '0;
        rt_sat[c]  <= (sq_c[c][sem_pkg::SQ_W-1:sem_pkg::ROOT_W] != '0);
      end else if (state == sem_pkg::S_ROOT) begin
        rt_val[c]  <= val_c[c];
        rt_root[c] <= root_c[c];
      end
    end
    if (out_load) begin
      edge_red   <= rt_sat[0] ? sem_pkg::EDGE_MAX : rt_root[0][sem_pkg::PIX_W-1:0];
      edge_green <= rt_sat[1] ? sem_pkg::EDGE_MAX : rt_root[1][sem_pkg::PIX_W-1:0];
      edge_blue  <= rt_sat[2] ? sem_pkg::EDGE_MAX : rt_root[2][sem_pkg::PIX_W-1:0];
      frame_last <= last_reg;
    end
  end

`ifndef ASSERT_OFF
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == sem_pkg::S_GRAD) |-> (col_reg <= col_last))
    else $error("line memory column beyond row length");

  a_root_exit: assert property (@(posedge clk) disable iff (rst)
    (state == sem_pkg::S_ROOT && step == sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1))
    |=> (state == sem_pkg::S_DONE))
    else $error("root unit did not finish after its last step");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == sem_pkg::S_DONE) |->
    (rt_root[0][sem_pkg::ROOT_W-1:sem_pkg::PIX_W] == '0) &&
    (rt_root[1][sem_pkg::ROOT_W-1:sem_pkg::PIX_W] == '0) &&
    (rt_root[2][sem_pkg::ROOT_W-1:sem_pkg::PIX_W] == '0))
    else $error("root exceeds eight bits");

  a_word_source: assert property (@(posedge clk) disable iff (rst)
    $rose(edge_valid) |-> ($past(state) == sem_pkg::S_DONE && $past(emit_reg)))
    else $error("result word raised without an interior pixel");
`endif

endmodule

### bench/sem_edge_checker.sv
`timescale 1ns / 1ps

module sem_edge_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          pixel_valid,
  input  logic                          pixel_ready,
  input  sem_pkg::pix_t                 pixel_red,
  input  sem_pkg::pix_t                 pixel_green,
  input  sem_pkg::pix_t                 pixel_blue,
  input  logic                          edge_valid,
  input  logic                          edge_ready,
  input  sem_pkg::pix_t                 edge_red,
  input  sem_pkg::pix_t                 edge_green,
  input  sem_pkg::pix_t                 edge_blue,
  input  logic                          frame_last,
  output int                            mismatch_count,
  output int                            edges_outstanding
);

  typedef struct packed {
    sem_pkg::pix_t blue;
    sem_pkg::pix_t green;
    sem_pkg::pix_t red;
  } rgb_t;

  typedef struct packed {
    sem_pkg::pix_t red;
    sem_pkg::pix_t green;
    sem_pkg::pix_t blue;
    logic          last;
  } edge_word_t;

  logic [sem_pkg::CFG_W-1:0] width_reg;
  logic [sem_pkg::CFG_W-1:0] height_reg;
  rgb_t             upper_row [sem_pkg::MAX_ROW_PIXELS];
  rgb_t             middle_row [sem_pkg::MAX_ROW_PIXELS];
  rgb_t             left_cols [2][3];   // [column][row], column 0 oldest
  rgb_t             frame_win [3][3];   // [column][row] of the pixel being scored
  int               col_pos;
  int               row_pos;
  edge_word_t       edge_queue [$];

  function automatic int clamp_dim(input int v, input int hi);
    if (v < sem_pkg::MIN_DIM) return sem_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic sem_pkg::pix_t chan(input rgb_t p, input int c);
    case (c)
      0:       return p.red;
      1:       return p.green;
      default: return p.blue;
    endcase
  endfunction

  function automatic sem_pkg::pix_t channel_magnitude(input int c);
    int p [3][3];
    int gx;
    int gy;
    int sq;
    int root;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        p[r][k] = chan(frame_win[k][r], c);
      end
    end
    gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
    gy = (p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
    sq = gx * gx + gy * gy;
    if (sq >= 65536) return sem_pkg::EDGE_MAX;
    root = 0;
    for (int b = 128; b > 0; b = b >> 1) begin
      if ((root + b) * (root + b) <= sq) root = root + b;
    end
    return sem_pkg::pix_t'(root);
  endfunction

  task automatic advance_raster(input rgb_t px);
    int w;
    int h;
    int col;
    int row;
    edge_word_t word;
    w = clamp_dim(int'(width_reg), sem_pkg::MAX_ROW_PIXELS);
    h = clamp_dim(int'(height_reg), sem_pkg::MAX_ROWS);
    // a counter past a shrunken bound stands on the last position
    col = (col_pos >= w) ? w - 1 : col_pos;
    row = (row_pos >= h) ? h - 1 : row_pos;
    for (int r = 0; r < 3; r++) begin
      frame_win[0][r] = left_cols[0][r];
      frame_win[1][r] = left_cols[1][r];
    end
    frame_win[2][0] = upper_row[col];
    frame_win[2][1] = middle_row[col];
    frame_win[2][2] = px;
    if (row >= 2 && col >= 2) begin
      word.red   = channel_magnitude(0);
      word.green = channel_magnitude(1);
      word.blue  = channel_magnitude(2);
      word.last  = (row == h - 1) && (col == w - 1);
      edge_queue.push_back(word);
    end
    upper_row[col]  = frame_win[2][1];
    middle_row[col] = px;
    for (int r = 0; r < 3; r++) begin
      left_cols[0][r] = frame_win[1][r];
      left_cols[1][r] = frame_win[2][r];
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    edge_word_t got;
    edge_word_t want;
    if (rst) begin
      width_reg      = sem_pkg::WIDTH_RESET;
      height_reg     = sem_pkg::HEIGHT_RESET;
      col_pos        = 0;
      row_pos        = 0;
      mismatch_count = 0;
      for (int i = 0; i < sem_pkg::MAX_ROW_PIXELS; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        left_cols[0][r] = '0;
        left_cols[1][r] = '0;
      end
      edge_queue.delete();
    end else begin
      // retire the output word first: a word never leaves in its own pixel's cycle
      if (edge_valid && edge_ready) begin
        got = {edge_red, edge_green, edge_blue, frame_last};
        if (edge_queue.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected edge word r=%0d g=%0d b=%0d last=%0b",
                   $time, got.red, got.green, got.blue, got.last);
        end else begin
          want = edge_queue.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: edge word mismatch, expected r=%0d g=%0d b=%0d last=%0b",
                     $time, want.red, want.green, want.blue, want.last);
            $display("%0t:                        actual r=%0d g=%0d b=%0d last=%0b",
                     $time, got.red, got.green, got.blue, got.last);
          end
        end
      end
      // a size written at this edge applies from the next pixel on
      if (pixel_valid && pixel_ready) begin
        advance_raster({pixel_blue, pixel_green, pixel_red});
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sem_pkg::CFG_FRAME_WIDTH) begin
          width_reg = cfg_data;
        end else if (cfg_index == sem_pkg::CFG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
        end
      end
    end
    edges_outstanding = edge_queue.size();
  end

endmodule

### bench/tb_sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_rgb;

  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PIXELS = 600;
  localparam int FILL_WIDTH    = 16;
  localparam logic [sem_pkg::CFG_IDX_W-1:0] CFG_SPARE = sem_pkg::CFG_IDX_W'(3);

  typedef enum int { FLOW_FREE, FLOW_SLOW_SOURCE, FLOW_SLOW_SINK, FLOW_BOTH } flow_t;
  typedef enum int { TEX_NOISE, TEX_SMOOTH, TEX_SPARSE } texture_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sem_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          pixel_valid = 1'b0;
  logic                          pixel_ready;
  sem_pkg::pix_t                 pixel_red = '0;
  sem_pkg::pix_t                 pixel_green = '0;
  sem_pkg::pix_t                 pixel_blue = '0;
  logic                          edge_valid;
  logic                          edge_ready = 1'b0;
  sem_pkg::pix_t                 edge_red;
  sem_pkg::pix_t                 edge_green;
  sem_pkg::pix_t                 edge_blue;
  logic                          frame_last;
  int                            mismatch_count;
  int                            edges_outstanding;

  int            source_idle_pct = 0;
  int            sink_stall_pct = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  texture_t      texture = TEX_NOISE;
  sem_pkg::pix_t tex_base [3];
  int            tex_spread = 0;

  always #5 clk = ~clk;

  sobel_edge_magnitude_rgb uut (.*);

  sem_edge_checker checker_i (.*);

  // sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      edge_ready <= 1'b0;
    end else if (hold_requests > holds_served) begin
      holds_served = holds_served + 1;
      hold_left = HOLD_CYCLES - 1;
      edge_ready <= 1'b0;
    end else begin
      edge_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (edge_valid && edge_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_dim();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, sem_pkg::MIN_DIM - 1);
    return $urandom_range(sem_pkg::MIN_DIM, 10);
  endfunction

  function automatic int eff_dim(input int v);
    return (v < sem_pkg::MIN_DIM) ? sem_pkg::MIN_DIM : v;
  endfunction

  task automatic set_flow(input flow_t f);
    @(posedge clk);
    source_idle_pct = (f == FLOW_SLOW_SOURCE) ? 70 : (f == FLOW_BOTH) ? 36 : 0;
    sink_stall_pct  = (f == FLOW_SLOW_SINK) ? 70 : (f == FLOW_BOTH) ? 36 : 0;
    @(negedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes never toggle it in one step
  task automatic write_reg(input logic [sem_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sem_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(sem_pkg::CFG_FRAME_WIDTH, sem_pkg::CFG_W'(w));
    write_reg(sem_pkg::CFG_FRAME_HEIGHT, sem_pkg::CFG_W'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pixel(input sem_pkg::pix_t r, input sem_pkg::pix_t g,
                            input sem_pkg::pix_t b);
    while ($urandom_range(0, 99) < source_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_red   <= r;
    pixel_green <= g;
    pixel_blue  <= b;
    do @(posedge clk); while (!pixel_ready);
    @(negedge clk);
  endtask

  task automatic pick_texture();
    texture = texture_t'($urandom_range(0, 2));
    tex_spread = $urandom_range(2, 40);
    for (int k = 0; k < 3; k++) begin
      tex_base[k] = sem_pkg::pix_t'($urandom_range(0, 255 - tex_spread));
    end
  endtask

  task automatic push_textured();
    sem_pkg::pix_t c [3];
    for (int k = 0; k < 3; k++) begin
      case (texture)
        TEX_NOISE:  c[k] = sem_pkg::pix_t'($urandom);
        TEX_SMOOTH: c[k] = tex_base[k] + sem_pkg::pix_t'($urandom_range(0, tex_spread));
        default:    c[k] = ($urandom_range(0, 9) == 0) ? '1 : '0;
      endcase
    end
    push_pixel(c[0], c[1], c[2]);
  endtask

  // drop valid, wait for every word, then let a border pixel finish
  task automatic settle();
    pixel_valid <= 1'b0;
    while (edges_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int w;
    int h;
    int count;
    int sent;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sizes below range clamp to 3x3
    set_size(0, 2);
    // step in red saturates, green flat, one blue corner gives a small root
    for (int i = 0; i < 9; i++) begin
      push_pixel((i % 3 == 2) ? 8'hFF : 8'h00, 8'h80, (i == 2) ? 8'd10 : 8'd0);
    end
    for (int i = 0; i < 9; i++) push_pixel('1, '1, '1);
    for (int i = 0; i < 9; i++) begin
      push_pixel(sem_pkg::pix_t'(20 * (i % 3)), sem_pkg::pix_t'(20 * (i / 3)),
                 sem_pkg::pix_t'(50 * (i % 3) + 30 * (i / 3)));
    end
    settle();

    // wide frame: writes every line-store entry that later sizes reach
    set_size(FILL_WIDTH, 3);
    pick_texture();
    repeat (3 * FILL_WIDTH) push_textured();
    settle();

    // tallest frame, then cut it short mid-frame
    set_size(3, 2047);
    repeat (30) push_textured();
    settle();
    write_reg(sem_pkg::CFG_FRAME_HEIGHT, sem_pkg::CFG_W'(5));
    cfg_valid <= 1'b0;
    repeat (18) push_textured();
    settle();
    write_reg(CFG_SPARE, '1);
    cfg_valid <= 1'b0;
    repeat (9) push_textured();
    settle();

    // long sink hold-off while the source keeps offering
    set_size(12, 8);
    @(posedge clk);
    hold_requests = hold_requests + 1;
    @(negedge clk);
    pick_texture();
    repeat (96) push_textured();
    settle();

    for (int f = 0; f < 4; f++) begin
      set_flow(flow_t'(f));
      sent = 0;
      while (sent < RANDOM_PIXELS / 4) begin
        w = pick_dim();
        h = pick_dim();
        set_size(w, h);
        count = eff_dim(w) * eff_dim(h) * $urandom_range(1, 2);
        // now and then stop mid-frame so the next size lands inside a frame
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count - 1);
        pick_texture();
        repeat (count) push_textured();
        sent += count;
        settle();
      end
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
